// ===== design/lif_pkg.sv =====
// shared types, constants and saturating helpers for the integrate-and-fire neuron
package lif_pkg;

    localparam int CW = 24;           // charge width, signed Q8.16
    localparam int EW = CW + 2;       // extended width for sums before saturation
    localparam int DW = CW - 1;       // decay rate width, unsigned
    localparam int MW = 5;            // mode register width
    localparam int IW = 3;            // configuration register index width

    typedef logic signed [CW-1:0] t_charge;
    typedef logic signed [EW-1:0] t_wide;

    // configuration register indexes
    typedef enum logic [IW-1:0] {
        REG_DECAY_RATE      = 3'd0,
        REG_THRESHOLD_LEVEL = 3'd1,
        REG_THRESHOLD_MIN   = 3'd2,
        REG_THRESHOLD_MAX   = 3'd3,
        REG_DELIVERY_LEVEL  = 3'd4,
        REG_DELIVERY_MIN    = 3'd5,
        REG_DELIVERY_MAX    = 3'd6,
        REG_MODE_BITS       = 3'd7
    } t_reg_index;

    // discharge behavior after firing
    typedef enum logic [1:0] {
        DIS_CLEAR  = 2'd0,
        DIS_REDUCE = 2'd1,
        DIS_HALVE  = 2'd2,
        DIS_NONE   = 2'd3
    } t_discharge;

    // mode bit positions
    localparam int MODE_ACTIVATE  = 2;
    localparam int MODE_THR_NODE  = 3;
    localparam int MODE_DEL_NODE  = 4;

    localparam t_charge CHARGE_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam t_charge CHARGE_MIN = {1'b1, {(CW-1){1'b0}}};

    localparam logic [MW-1:0] MODE_RESET       = MW'(4);
    localparam t_charge       THR_LEVEL_RESET  = t_charge'(0);
    localparam t_charge       THR_MIN_RESET    = t_charge'(-65536);
    localparam t_charge       THR_MAX_RESET    = t_charge'(65536);
    localparam t_charge       DEL_LEVEL_RESET  = t_charge'(65536);
    localparam t_charge       DEL_MIN_RESET    = t_charge'(-65536);
    localparam t_charge       DEL_MAX_RESET    = t_charge'(65536);

    function automatic t_wide widen(input t_charge v);
        return t_wide'(v);
    endfunction

    // saturate an extended value to the signed charge range
    function automatic t_charge sat(input t_wide v);
        t_charge r;
        if (v > widen(CHARGE_MAX)) begin
            r = CHARGE_MAX;
        end else if (v < widen(CHARGE_MIN)) begin
            r = CHARGE_MIN;
        end else begin
            r = v[CW-1:0];
        end
        return r;
    endfunction

    // max(lo, min(hi, x)); inverted limits give lo
    function automatic t_charge clip(input t_charge x, input t_charge lo, input t_charge hi);
        t_charge t;
        t = (x < hi) ? x : hi;
        return (t > lo) ? t : lo;
    endfunction

endpackage

// ===== design/leaky_integrate_fire_neuron.sv =====
// leaky integrate-and-fire neuron: input register, one-pass update logic, result register
//
// One request is one neuron tick. While the result side is not stalled, the block
// takes a request in every clock cycle and passes it through the input register and
// result register; the sustained rate is one tick per cycle. The request lands in an
// input register, then a single combinational pass (decay toward zero, three saturating
// adds, threshold compare, delivery clip and discharge) updates the membrane charge
// register and the result register in the same edge, so the next tick sees the new
// charge right away. Charge, thresholds and delivery are signed Q8.16 in 24 bits. The
// configuration registers are written through a plain write port (index 0 decay rate
// up to index 7 mode bits) and must only be written while no tick is in flight.
module leaky_integrate_fire_neuron (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration write port
    input  logic                         i_cfg_we,
    input  logic [lif_pkg::IW-1:0]       i_cfg_index,
    input  logic [lif_pkg::CW-1:0]       i_cfg_data,
    // request channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [lif_pkg::CW-1:0] i_in_a,
    input  logic signed [lif_pkg::CW-1:0] i_in_b,
    input  logic signed [lif_pkg::CW-1:0] i_in_c,
    input  logic signed [lif_pkg::CW-1:0] i_threshold_node,
    input  logic signed [lif_pkg::CW-1:0] i_delivery_node,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_fired,
    output logic signed [lif_pkg::CW-1:0] o_delivered_charge,
    output logic signed [lif_pkg::CW-1:0] o_charge_now
);
    import lif_pkg::*;

    // configuration registers
    logic [DW-1:0] r_decay_rate;
    t_charge       r_thr_level, r_thr_min, r_thr_max;
    t_charge       r_del_level, r_del_min, r_del_max;
    logic [MW-1:0] r_mode;

    // input register
    logic          r_in_valid;
    t_charge       r_a, r_b, r_c, r_thr_node, r_del_node;

    // neuron state
    t_charge       r_charge;

    // result register
    logic          r_out_valid;
    logic          r_fired;
    t_charge       r_delivered, r_charge_now;

    // update pass signals
    logic          advance;
    logic          in_take;
    t_charge       n_charge;
    t_charge       decayed, sum1, sum2, sum3;
    t_charge       thr, del_raw, del_clip;
    t_wide         c_ext, d_ext, del_abs;
    logic          fire;
    t_discharge    dis_mode;

    // the update fires whenever a request waits and the result slot is free or draining
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign in_take    = !r_in_valid || advance;
    assign o_in_stall = !in_take;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay_rate <= '0;
            r_thr_level  <= THR_LEVEL_RESET;
            r_thr_min    <= THR_MIN_RESET;
            r_thr_max    <= THR_MAX_RESET;
            r_del_level  <= DEL_LEVEL_RESET;
            r_del_min    <= DEL_MIN_RESET;
            r_del_max    <= DEL_MAX_RESET;
            r_mode       <= MODE_RESET;
        end else if (i_cfg_we) begin
            case (t_reg_index'(i_cfg_index))
                REG_DECAY_RATE:      r_decay_rate <= i_cfg_data[DW-1:0];
                REG_THRESHOLD_LEVEL: r_thr_level  <= i_cfg_data;
                REG_THRESHOLD_MIN:   r_thr_min    <= i_cfg_data;
                REG_THRESHOLD_MAX:   r_thr_max    <= i_cfg_data;
                REG_DELIVERY_LEVEL:  r_del_level  <= i_cfg_data;
                REG_DELIVERY_MIN:    r_del_min    <= i_cfg_data;
                REG_DELIVERY_MAX:    r_del_max    <= i_cfg_data;
                REG_MODE_BITS:       r_mode       <= i_cfg_data[MW-1:0];
                default: ;
            endcase
        end
    end

    // input register: refills whenever it is empty or being consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take && i_in_valid) begin
            r_a        <= i_in_a;
            r_b        <= i_in_b;
            r_c        <= i_in_c;
            r_thr_node <= i_threshold_node;
            r_del_node <= i_delivery_node;
        end
    end

    // one tick of the neuron
    always_comb begin
        d_ext = t_wide'({1'b0, r_decay_rate});
        c_ext = widen(r_charge);

        // leak toward zero, may overshoot
        if (r_charge > 0) begin
            decayed = sat(c_ext - d_ext);
        end else if (r_charge < 0) begin
            decayed = sat(c_ext + d_ext);
        end else begin
            decayed = r_charge;
        end

        // integrate the three inputs, saturating after each add
        sum1 = sat(widen(decayed) + widen(r_a));
        sum2 = sat(widen(sum1) + widen(r_b));
        sum3 = sat(widen(sum2) + widen(r_c));

        thr = r_mode[MODE_THR_NODE] ? clip(r_thr_node, r_thr_min, r_thr_max) : r_thr_level;

        // activate fires above threshold, repress fires below it
        fire = r_mode[MODE_ACTIVATE] ? (sum3 > thr) : (sum3 < thr);

        del_raw  = r_mode[MODE_DEL_NODE] ? r_del_node : r_del_level;
        del_clip = clip(del_raw, r_del_min, r_del_max);
        del_abs  = (del_clip < 0) ? -widen(del_clip) : widen(del_clip);

        dis_mode = t_discharge'(r_mode[1:0]);
        n_charge = sum3;
        if (fire) begin
            case (dis_mode)
                DIS_CLEAR: begin
                    n_charge = '0;
                end
                DIS_REDUCE: begin
                    // shrink the magnitude, can cross zero
                    if (sum3 > 0) begin
                        n_charge = sat(widen(sum3) - del_abs);
                    end else if (sum3 < 0) begin
                        n_charge = sat(widen(sum3) + del_abs);
                    end
                end
                DIS_HALVE: begin
                    // arithmetic shift rounds toward minus infinity
                    n_charge = sum3 >>> 1;
                end
                default: begin
                    n_charge = sum3;
                end
            endcase
        end
    end

    // charge state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_charge    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_charge <= n_charge;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_fired      <= fire;
            r_delivered  <= fire ? del_clip : '0;
            r_charge_now <= n_charge;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_fired            = r_fired;
    assign o_delivered_charge = r_delivered;
    assign o_charge_now       = r_charge_now;

`ifndef NO_ASSERTIONS
    // a quiet tick delivers nothing
    a_quiet_no_delivery: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_fired) |-> (r_delivered == '0))
        else $error("nonzero delivery without firing");

    // the reported charge is the stored state
    a_charge_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_charge == r_charge_now))
        else $error("reported charge differs from stored charge");

    // clear discharge leaves zero charge after a firing tick
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && fire && (r_mode[1:0] == DIS_CLEAR)) |=> (r_charge_now == '0))
        else $error("clear discharge left charge");

    // delivered charge respects ordered clip limits
    a_delivery_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_fired && (r_del_min <= r_del_max))
            |-> ((r_delivered >= r_del_min) && (r_delivered <= r_del_max)))
        else $error("delivered charge outside clip limits");

    // a waiting request never overwrites an undelivered result
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !advance)
        else $error("result overwritten while stalled");
`endif

endmodule
